// ----- hdl/prs_pkg.sv -----
// ----------------------------------------------------------------------------
// prs_pkg
// shared types and constants for the pattern removal stream
// ----------------------------------------------------------------------------
package prs_pkg;

  // default pattern capacity in bytes, also the pending window depth
  localparam int PATTERN_MAX_DEF = 16;

  // fixed widths of the configuration registers
  localparam int LEN_W     = 5;
  localparam int HALF_W    = 64;
  localparam int PAT_W     = 2 * HALF_W;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LENGTH = 2'd0,
    REG_LOW    = 2'd1,
    REG_HIGH   = 2'd2
  } cfg_reg_t;

  // one scan decision on the pending window
  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_EMIT = 2'd1,
    ACT_DROP = 2'd2
  } act_t;

  typedef struct packed {
    logic append;
    act_t act;
  } win_ctl_t;

endpackage

// ----- hdl/prs_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// prs_cfg_regs
// configuration registers, pattern bytes and clamped pattern length
// ----------------------------------------------------------------------------
module prs_cfg_regs #(
  parameter int PATTERN_MAX = prs_pkg::PATTERN_MAX_DEF,
  localparam int CNT_W = $clog2(PATTERN_MAX + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [prs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [prs_pkg::HALF_W-1:0]    cfg_data,
  output logic [CNT_W-1:0]              act_len,
  output logic [prs_pkg::PAT_W-1:0]     pattern
);

  logic [prs_pkg::LEN_W-1:0]  len_r;
  logic [prs_pkg::HALF_W-1:0] low_r;
  logic [prs_pkg::HALF_W-1:0] high_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      low_r  <= '0;
      high_r <= '0;
    end else if (cfg_valid) begin
      case (prs_pkg::cfg_reg_t'(cfg_index))
        prs_pkg::REG_LENGTH: len_r  <= cfg_data[prs_pkg::LEN_W-1:0];
        prs_pkg::REG_LOW:    low_r  <= cfg_data;
        prs_pkg::REG_HIGH:   high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // lengths above capacity act as full capacity
  always_comb begin
    if (len_r > prs_pkg::LEN_W'(PATTERN_MAX)) begin
      act_len = CNT_W'(PATTERN_MAX);
    end else begin
      act_len = len_r[CNT_W-1:0];
    end
  end

  assign pattern = {high_r, low_r};

endmodule

// ----- hdl/prs_match.sv -----
// ----------------------------------------------------------------------------
// prs_match
// parallel compare of the oldest window bytes with the pattern
// ----------------------------------------------------------------------------
module prs_match #(
  parameter int PATTERN_MAX = prs_pkg::PATTERN_MAX_DEF,
  localparam int CNT_W = $clog2(PATTERN_MAX + 1)
) (
  input  logic [PATTERN_MAX*8-1:0]  cand_flat,
  input  logic [prs_pkg::PAT_W-1:0] pattern,
  input  logic [CNT_W-1:0]          act_len,
  output logic                      match
);

  // bytes at or beyond the active length do not take part
  always_comb begin
    match = 1'b1;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if ((CNT_W'(i) < act_len) && (cand_flat[i*8 +: 8] != pattern[i*8 +: 8])) begin
        match = 1'b0;
      end
    end
  end

endmodule

// ----- hdl/prs_window.sv -----
// ----------------------------------------------------------------------------
// prs_window
// pending byte window with append and variable front drop
// ----------------------------------------------------------------------------
module prs_window #(
  parameter int PATTERN_MAX = prs_pkg::PATTERN_MAX_DEF,
  localparam int CNT_W = $clog2(PATTERN_MAX + 1),
  localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  prs_pkg::win_ctl_t        ctl,
  input  logic [7:0]               in_byte,
  input  logic [CNT_W-1:0]         act_len,
  output logic [PATTERN_MAX*8-1:0] cand_flat,
  output logic [CNT_W-1:0]         cand_cnt,
  output logic [7:0]               front_byte
);

  logic [7:0]       win_r   [PATTERN_MAX];
  logic [7:0]       win_nxt [PATTERN_MAX];
  logic [7:0]       cand    [PATTERN_MAX];
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [IDX_W-1:0] aidx;
  logic [CNT_W-1:0] sh;

  // window with the incoming byte placed after the pending ones
  always_comb begin
    if (cnt_r >= CNT_W'(PATTERN_MAX)) begin
      aidx = IDX_W'(PATTERN_MAX - 1);
    end else begin
      aidx = cnt_r[IDX_W-1:0];
    end
    if (!ctl.append) begin
      cand_cnt = cnt_r;
    end else if (cnt_r >= CNT_W'(PATTERN_MAX)) begin
      cand_cnt = CNT_W'(PATTERN_MAX);
    end else begin
      cand_cnt = cnt_r + 1'b1;
    end
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (ctl.append && (aidx == IDX_W'(i))) begin
        cand[i] = in_byte;
      end else begin
        cand[i] = win_r[i];
      end
      cand_flat[i*8 +: 8] = cand[i];
    end
  end

  assign front_byte = cand[0];

  // drop amount from the decision
  always_comb begin
    case (ctl.act)
      prs_pkg::ACT_EMIT: sh = CNT_W'(1);
      prs_pkg::ACT_DROP: sh = act_len;
      default:           sh = '0;
    endcase
  end

  always_comb begin
    logic [CNT_W:0] idx;
    idx = '0;
    for (int j = 0; j < PATTERN_MAX; j++) begin
      idx = (CNT_W+1)'(j) + {1'b0, sh};
      if (idx < (CNT_W+1)'(PATTERN_MAX)) begin
        win_nxt[j] = cand[idx[IDX_W-1:0]];
      end else begin
        win_nxt[j] = cand[j];
      end
    end
    cnt_nxt = cand_cnt - sh;
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < PATTERN_MAX; j++) begin
      win_r[j] <= win_nxt[j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- hdl/pattern_removal_stream.sv -----
// ----------------------------------------------------------------------------
// pattern_removal_stream
// removes every leftmost non-overlapping occurrence of a byte pattern
// ----------------------------------------------------------------------------
// A byte stream enters one item per cycle unless the output stalls, and
// leaves with every leftmost, non-overlapping occurrence of the configured
// pattern (up to PATTERN_MAX bytes) removed. Each cycle the scan logic makes
// one decision on the pending window: drop a matching front, emit the oldest
// byte, or stand still. In a steady stream an item is taken every cycle,
// since the window compare and front drop run in parallel between the window
// register and the result register. An item with end_of_data set drains the
// window one byte per cycle and then closes the stream, so it holds the input
// until the window is empty; the last result is held back one slot so that
// out_last can be placed once the end is known. After the pattern length is
// reconfigured mid-stream, the next item may stay busy until the surplus
// pending bytes are worked off. Output stalls stall the scan; there is no
// clearing pass after reset. Configuration writes are taken every cycle.
// ----------------------------------------------------------------------------
module pattern_removal_stream #(
  parameter int PATTERN_MAX = prs_pkg::PATTERN_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input items
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_data_byte,
  input  logic                          in_end_of_data,
  // result items
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_byte,
  output logic                          out_has_byte,
  output logic                          out_last,
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [prs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [prs_pkg::HALF_W-1:0]    cfg_data
);

  localparam int CNT_W = $clog2(PATTERN_MAX + 1);

  logic [CNT_W-1:0]          act_len;
  logic [prs_pkg::PAT_W-1:0] pattern;
  logic [PATTERN_MAX*8-1:0]  cand_flat;
  logic [CNT_W-1:0]          cand_cnt;
  logic [7:0]                front_byte;
  logic                      match;
  prs_pkg::win_ctl_t         ctl;

  // control state
  logic busy_r, busy_nxt;
  logic flush_r, flush_nxt;
  logic hold_valid_r, hold_valid_nxt;
  logic [7:0] hold_byte_r, hold_byte_nxt;

  // result register
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_has_r;
  logic       out_last_r;

  logic             adv;
  logic             accept;
  logic             go;
  logic             last_mode;
  logic             full;
  logic             finalize;
  logic             settled;
  logic [CNT_W-1:0] sh_amt;
  logic [CNT_W-1:0] cnt_after;
  logic             push;
  logic [7:0]       push_byte;
  logic             push_has;
  logic             push_last;

  prs_cfg_regs #(.PATTERN_MAX(PATTERN_MAX)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .act_len   (act_len),
    .pattern   (pattern)
  );

  prs_window #(.PATTERN_MAX(PATTERN_MAX)) u_win (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .in_byte    (in_data_byte),
    .act_len    (act_len),
    .cand_flat  (cand_flat),
    .cand_cnt   (cand_cnt),
    .front_byte (front_byte)
  );

  prs_match #(.PATTERN_MAX(PATTERN_MAX)) u_match (
    .cand_flat (cand_flat),
    .pattern   (pattern),
    .act_len   (act_len),
    .match     (match)
  );

  // the scan moves only when the result register can take a new item
  assign adv      = !out_valid_r || out_ready;
  // a new item is taken once the previous one has settled
  assign in_ready = !busy_r && adv;
  assign accept   = in_valid && in_ready;
  assign go       = adv && (accept || busy_r);
  // end-of-stream handling follows the item being worked on
  assign last_mode = accept ? in_end_of_data : flush_r;
  // window holds at least a full pattern
  assign full = (act_len != '0) && (cand_cnt >= act_len);

  // scan decision
  always_comb begin
    ctl.append = accept;
    ctl.act    = prs_pkg::ACT_NONE;
    if (go) begin
      if (full && match) begin
        ctl.act = prs_pkg::ACT_DROP;
      end else if (full || ((act_len == '0) && (cand_cnt != '0)) ||
                   (last_mode && (cand_cnt != '0))) begin
        ctl.act = prs_pkg::ACT_EMIT;
      end
    end
  end

  // end of stream closes once the window is empty
  assign finalize = go && last_mode && (cand_cnt == '0);

  always_comb begin
    case (ctl.act)
      prs_pkg::ACT_EMIT: sh_amt = CNT_W'(1);
      prs_pkg::ACT_DROP: sh_amt = act_len;
      default:           sh_amt = '0;
    endcase
    cnt_after = cand_cnt - sh_amt;
    // nothing more to do for this item without a new byte
    if (act_len == '0) begin
      settled = (cnt_after == '0);
    end else begin
      settled = (cnt_after < act_len);
    end
  end

  // result routing, the final stream byte waits in the hold slot
  always_comb begin
    push           = 1'b0;
    push_byte      = '0;
    push_has       = 1'b0;
    push_last      = 1'b0;
    hold_valid_nxt = hold_valid_r;
    hold_byte_nxt  = hold_byte_r;
    if (ctl.act == prs_pkg::ACT_EMIT) begin
      if (!last_mode) begin
        push      = 1'b1;
        push_byte = front_byte;
        push_has  = 1'b1;
      end else begin
        push           = hold_valid_r;
        push_byte      = hold_byte_r;
        push_has       = 1'b1;
        hold_valid_nxt = 1'b1;
        hold_byte_nxt  = front_byte;
      end
    end
    if (finalize) begin
      // held byte closes the stream, or an empty end marker does
      push           = 1'b1;
      push_has       = hold_valid_r;
      push_byte      = hold_valid_r ? hold_byte_r : 8'h00;
      push_last      = 1'b1;
      hold_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    busy_nxt  = busy_r;
    flush_nxt = flush_r;
    if (go) begin
      flush_nxt = last_mode && !finalize;
      busy_nxt  = last_mode ? !finalize : !settled;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      flush_r      <= 1'b0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      busy_r       <= busy_nxt;
      flush_r      <= flush_nxt;
      hold_valid_r <= hold_valid_nxt;
      if (adv) begin
        out_valid_r <= push;
      end
    end
  end

  always_ff @(posedge clk) begin
    hold_byte_r <= hold_byte_nxt;
    if (adv && push) begin
      out_byte_r <= push_byte;
      out_has_r  <= push_has;
      out_last_r <= push_last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_byte     = out_byte_r;
  assign out_has_byte = out_has_r;
  assign out_last     = out_last_r;

  // end-of-stream mode only while an item is in progress
  a_flush_busy: assert property (@(posedge clk) disable iff (!rst_n)
    flush_r |-> busy_r)
    else $error("flush active without a busy item");

  // the hold slot is used only while closing a stream
  a_hold_flush: assert property (@(posedge clk) disable iff (!rst_n)
    hold_valid_r |-> flush_r)
    else $error("held byte outside end of stream");

  // closing a stream leaves the block free and the hold slot empty
  a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
    finalize |=> (!busy_r && !hold_valid_r))
    else $error("stream close did not return to idle");

  // an empty result only ever marks the end of a stream
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_has_byte) |-> out_last)
    else $error("empty result without end marker");

endmodule
